// ===== rtl/src_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// src_pkg: shared types and codes of the segment and rectangle collision block
// Holds the action and register codes, the three-valued sign code with its
// helper, and the control structs passed between the sequencer and the
// entry test pipeline.
// ----------------------------------------------------------------------------
package src_pkg;

    localparam int ACTION_W    = 2;
    localparam int EXTENT_W    = 16;
    localparam int MARGIN_W    = 16;
    localparam int COUNT_OUT_W = 7;
    localparam int OUT_DW      = 16;
    localparam int OUT_PAD_W   = OUT_DW - COUNT_OUT_W - 2;

    // Item actions carried in tuser.
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_X_MARGIN = 1'b0;
    localparam logic CFG_Y_MARGIN = 1'b1;

    // Three-valued orientation sign.
    typedef logic [1:0] t_sgn;
    localparam t_sgn SG_ZERO = 2'd0;
    localparam t_sgn SG_POS  = 2'd1;
    localparam t_sgn SG_NEG  = 2'd2;

    // Signs of the side-relative orientations of both segment endpoints.
    typedef struct packed {
        t_sgn top_a;
        t_sgn top_b;
        t_sgn bot_a;
        t_sgn bot_b;
        t_sgn lft_a;
        t_sgn lft_b;
        t_sgn rgt_a;
        t_sgn rgt_b;
    } t_side_sgn;

    // Tag of one table entry entering the test pipeline.
    typedef struct packed {
        logic vld;
        logic last;
    } t_ent_tag;

    // Verdict of one table entry leaving the test pipeline.
    typedef struct packed {
        logic vld;
        logic last;
        logic touch;
    } t_touch_res;

    function automatic t_sgn sgn_code(input logic is_zero, input logic is_neg);
        t_sgn code;
        if (is_zero) begin
            code = SG_ZERO;
        end else if (is_neg) begin
            code = SG_NEG;
        end else begin
            code = SG_POS;
        end
        return code;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/src_obs_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// src_obs_table: obstacle bound table
// Widens an appended obstacle by its half extents and the margins, saturates
// the four bounds and stores them; reads one entry per cycle with registered
// read data.
// ----------------------------------------------------------------------------
module src_obs_table #(
    parameter int COORD_WIDTH   = 24,
    parameter int MAX_OBSTACLES = 64,
    localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1,
    localparam int BND_W = COORD_WIDTH + 1
) (
    input  logic                                i_clk,
    input  logic                                i_wr_en,
    input  logic [IDX_W-1:0]                    i_wr_idx,
    input  logic signed [COORD_WIDTH-1:0]       i_center_x,
    input  logic signed [COORD_WIDTH-1:0]       i_center_y,
    input  logic [src_pkg::EXTENT_W-1:0]        i_box_length,
    input  logic [src_pkg::EXTENT_W-1:0]        i_box_width,
    input  logic [src_pkg::MARGIN_W-1:0]        i_x_margin,
    input  logic [src_pkg::MARGIN_W-1:0]        i_y_margin,
    input  logic [IDX_W-1:0]                    i_rd_idx,
    output logic signed [BND_W-1:0]             o_left,
    output logic signed [BND_W-1:0]             o_right,
    output logic signed [BND_W-1:0]             o_top,
    output logic signed [BND_W-1:0]             o_bottom
);
    import src_pkg::*;

    localparam int HALF_W = EXTENT_W + 1;
    localparam int SUM_W  = ((COORD_WIDTH > HALF_W + 1) ? COORD_WIDTH : HALF_W + 1) + 1;
    localparam int ROW_W  = 4 * BND_W;
    localparam logic signed [SUM_W-1:0] B_HI =
        SUM_W'((64'sd1 <<< COORD_WIDTH) - 64'sd1);
    localparam logic signed [SUM_W-1:0] B_LO = ~B_HI;

    function automatic logic [BND_W-1:0] sat_bnd(input logic signed [SUM_W-1:0] v);
        logic [BND_W-1:0] res;
        if (v > B_HI) begin
            res = B_HI[BND_W-1:0];
        end else if (v < B_LO) begin
            res = B_LO[BND_W-1:0];
        end else begin
            res = v[BND_W-1:0];
        end
        return res;
    endfunction

    logic [HALF_W-1:0]        w_hx;
    logic [HALF_W-1:0]        w_hy;
    logic signed [SUM_W-1:0]  w_cx;
    logic signed [SUM_W-1:0]  w_cy;
    logic signed [SUM_W-1:0]  w_hx_s;
    logic signed [SUM_W-1:0]  w_hy_s;
    logic [ROW_W-1:0]         w_row;
    logic [ROW_W-1:0]         r_mem [MAX_OBSTACLES];
    logic [ROW_W-1:0]         r_rd_data;

    assign w_hx   = HALF_W'(i_box_length >> 1) + HALF_W'(i_x_margin);
    assign w_hy   = HALF_W'(i_box_width >> 1) + HALF_W'(i_y_margin);
    assign w_cx   = SUM_W'(i_center_x);
    assign w_cy   = SUM_W'(i_center_y);
    assign w_hx_s = signed'(SUM_W'(w_hx));
    assign w_hy_s = signed'(SUM_W'(w_hy));

    // Row layout from the top bit down: left, right, top, bottom.
    assign w_row = {sat_bnd(w_cx - w_hx_s), sat_bnd(w_cx + w_hx_s),
                    sat_bnd(w_cy + w_hy_s), sat_bnd(w_cy - w_hy_s)};

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= w_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_idx];
    end

    assign o_left   = signed'(r_rd_data[3*BND_W +: BND_W]);
    assign o_right  = signed'(r_rd_data[2*BND_W +: BND_W]);
    assign o_top    = signed'(r_rd_data[1*BND_W +: BND_W]);
    assign o_bottom = signed'(r_rd_data[0 +: BND_W]);

endmodule
`default_nettype wire

// ===== rtl/src_touch_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// src_touch_unit: segment against one rectangle, pipelined
// Takes one table entry per cycle and decides whether the held segment has
// an endpoint inside the rectangle or crosses one of its sides.
// ----------------------------------------------------------------------------
module src_touch_unit #(
    parameter int COORD_WIDTH = 24,
    localparam int BND_W = COORD_WIDTH + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  src_pkg::t_ent_tag             i_tag,
    input  logic signed [BND_W-1:0]       i_left,
    input  logic signed [BND_W-1:0]       i_right,
    input  logic signed [BND_W-1:0]       i_top,
    input  logic signed [BND_W-1:0]       i_bottom,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by,
    input  logic signed [BND_W-1:0]       i_dx,
    input  logic signed [BND_W-1:0]       i_dy,
    output src_pkg::t_touch_res           o_res
);
    import src_pkg::*;

    localparam int DW = COORD_WIDTH + 2;
    localparam int PW = BND_W + DW;
    localparam int OW = PW + 1;

    logic signed [BND_W-1:0] w_ax;
    logic signed [BND_W-1:0] w_ay;
    logic signed [BND_W-1:0] w_bx;
    logic signed [BND_W-1:0] w_by;
    logic                    w_eq_lr;
    logic                    w_eq_bt;
    logic                    w_in_a;
    logic                    w_in_b;
    t_side_sgn               w_side;

    // Stage 1: corner offsets, containment and side signs.
    t_ent_tag          r1_tag;
    logic signed [DW-1:0] r1_dl;
    logic signed [DW-1:0] r1_dr;
    logic signed [DW-1:0] r1_dt;
    logic signed [DW-1:0] r1_db;
    logic              r1_in;
    t_side_sgn         r1_side;

    // Stage 2: products.
    t_ent_tag          r2_tag;
    logic signed [PW-1:0] r2_p_yl;
    logic signed [PW-1:0] r2_p_yr;
    logic signed [PW-1:0] r2_p_xt;
    logic signed [PW-1:0] r2_p_xb;
    logic              r2_in;
    t_side_sgn         r2_side;

    // Stage 3: corner orientation signs.
    logic signed [OW-1:0] w_o_lt;
    logic signed [OW-1:0] w_o_rt;
    logic signed [OW-1:0] w_o_lb;
    logic signed [OW-1:0] w_o_rb;
    t_ent_tag          r3_tag;
    t_sgn              r3_c_lt;
    t_sgn              r3_c_rt;
    t_sgn              r3_c_lb;
    t_sgn              r3_c_rb;
    logic              r3_in;
    t_side_sgn         r3_side;

    logic              w_cross;
    t_touch_res        r4_res;

    assign w_ax = BND_W'(i_ax);
    assign w_ay = BND_W'(i_ay);
    assign w_bx = BND_W'(i_bx);
    assign w_by = BND_W'(i_by);

    assign w_eq_lr = (i_left == i_right);
    assign w_eq_bt = (i_bottom == i_top);

    assign w_in_a = (i_left <= w_ax) && (w_ax <= i_right) &&
                    (i_bottom <= w_ay) && (w_ay <= i_top);
    assign w_in_b = (i_left <= w_bx) && (w_bx <= i_right) &&
                    (i_bottom <= w_by) && (w_by <= i_top);

    // Bounds always satisfy left <= right and bottom <= top, so the side
    // orientations reduce to a compare of one coordinate.
    assign w_side.top_a = sgn_code(w_eq_lr || (i_top == w_ay), i_top < w_ay);
    assign w_side.top_b = sgn_code(w_eq_lr || (i_top == w_by), i_top < w_by);
    assign w_side.bot_a = sgn_code(w_eq_lr || (i_bottom == w_ay), i_bottom < w_ay);
    assign w_side.bot_b = sgn_code(w_eq_lr || (i_bottom == w_by), i_bottom < w_by);
    assign w_side.lft_a = sgn_code(w_eq_bt || (i_left == w_ax), i_left < w_ax);
    assign w_side.lft_b = sgn_code(w_eq_bt || (i_left == w_bx), i_left < w_bx);
    assign w_side.rgt_a = sgn_code(w_eq_bt || (i_right == w_ax), i_right < w_ax);
    assign w_side.rgt_b = sgn_code(w_eq_bt || (i_right == w_bx), i_right < w_bx);

    always_ff @(posedge i_clk) begin
        r1_dl   <= DW'(i_left) - DW'(i_bx);
        r1_dr   <= DW'(i_right) - DW'(i_bx);
        r1_dt   <= DW'(i_top) - DW'(i_by);
        r1_db   <= DW'(i_bottom) - DW'(i_by);
        r1_in   <= w_in_a || w_in_b;
        r1_side <= w_side;

        r2_p_yl <= PW'(i_dy) * PW'(r1_dl);
        r2_p_yr <= PW'(i_dy) * PW'(r1_dr);
        r2_p_xt <= PW'(i_dx) * PW'(r1_dt);
        r2_p_xb <= PW'(i_dx) * PW'(r1_db);
        r2_in   <= r1_in;
        r2_side <= r1_side;

        r3_c_lt <= sgn_code(w_o_lt == '0, w_o_lt[OW-1]);
        r3_c_rt <= sgn_code(w_o_rt == '0, w_o_rt[OW-1]);
        r3_c_lb <= sgn_code(w_o_lb == '0, w_o_lb[OW-1]);
        r3_c_rb <= sgn_code(w_o_rb == '0, w_o_rb[OW-1]);
        r3_in   <= r2_in;
        r3_side <= r2_side;
    end

    // Orientation of a corner against the segment: dy*(px-bx) - dx*(py-by).
    assign w_o_lt = OW'(r2_p_yl) - OW'(r2_p_xt);
    assign w_o_rt = OW'(r2_p_yr) - OW'(r2_p_xt);
    assign w_o_lb = OW'(r2_p_yl) - OW'(r2_p_xb);
    assign w_o_rb = OW'(r2_p_yr) - OW'(r2_p_xb);

    assign w_cross =
        ((r3_c_lt != r3_c_rt) && (r3_side.top_a != r3_side.top_b)) ||
        ((r3_c_lb != r3_c_rb) && (r3_side.bot_a != r3_side.bot_b)) ||
        ((r3_c_lt != r3_c_lb) && (r3_side.lft_a != r3_side.lft_b)) ||
        ((r3_c_rt != r3_c_rb) && (r3_side.rgt_a != r3_side.rgt_b));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag       <= '0;
            r2_tag       <= '0;
            r3_tag       <= '0;
            r4_res.vld   <= 1'b0;
            r4_res.last  <= 1'b0;
            r4_res.touch <= 1'b0;
        end else begin
            r1_tag       <= i_tag;
            r2_tag       <= r1_tag;
            r3_tag       <= r2_tag;
            r4_res.vld   <= r3_tag.vld;
            r4_res.last  <= r3_tag.last;
            r4_res.touch <= r3_in || w_cross;
        end
    end

    assign o_res = r4_res;

endmodule
`default_nettype wire

// ===== rtl/segment_rectangle_collision.sv =====
// A clear, an append or an unused action moves from acceptance to the done state and
// from there to the result register; so does a query on an empty table. A query on
// N stored obstacles first walks the table and lets the entry test pipeline drain.
// One item is in the block at a time; it reads one table entry per cycle through
// the entry test pipeline, so no new input word is taken while a query runs.
// Reset (synchronous, active low) empties the table and clears margins and flags.
`default_nettype none
// ----------------------------------------------------------------------------
// segment_rectangle_collision: segment versus obstacle table collision test
// Keeps a table of widened axis-aligned rectangles. Input words clear the
// table, append one obstacle, or query one segment against all entries.
// ----------------------------------------------------------------------------
module segment_rectangle_collision #(
    parameter int MAX_OBSTACLES = 64,
    parameter int COORD_WIDTH   = 24,
    localparam int IN_DW = ((6 * COORD_WIDTH + 2 * src_pkg::EXTENT_W + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // Input word: tdata from bit 0 up: seg_start_x, seg_start_y, seg_end_x,
    // seg_end_y, center_x, center_y, box_length, box_width, zero fill.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [IN_DW-1:0]                s_axis_tdata,
    // tuser: action.
    input  logic [src_pkg::ACTION_W-1:0]    s_axis_tuser,

    // Result word: tdata from bit 0 up: hit, status, stored_count, zero fill.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [src_pkg::OUT_DW-1:0]      m_axis_tdata,

    // Register writes: index 0 is x_margin, index 1 is y_margin.
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_addr,
    input  logic [src_pkg::MARGIN_W-1:0]    i_cfg_data
);
    import src_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int BND_W = W + 1;
    localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // Input word fields.
    logic signed [W-1:0]   w_seg_start_x;
    logic signed [W-1:0]   w_seg_start_y;
    logic signed [W-1:0]   w_seg_end_x;
    logic signed [W-1:0]   w_seg_end_y;
    logic signed [W-1:0]   w_center_x;
    logic signed [W-1:0]   w_center_y;
    logic [EXTENT_W-1:0]   w_box_length;
    logic [EXTENT_W-1:0]   w_box_width;

    assign w_seg_start_x = signed'(s_axis_tdata[0*W +: W]);
    assign w_seg_start_y = signed'(s_axis_tdata[1*W +: W]);
    assign w_seg_end_x   = signed'(s_axis_tdata[2*W +: W]);
    assign w_seg_end_y   = signed'(s_axis_tdata[3*W +: W]);
    assign w_center_x    = signed'(s_axis_tdata[4*W +: W]);
    assign w_center_y    = signed'(s_axis_tdata[5*W +: W]);
    assign w_box_length  = s_axis_tdata[6*W +: EXTENT_W];
    assign w_box_width   = s_axis_tdata[6*W + EXTENT_W +: EXTENT_W];

    // Control state.
    logic [1:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_rd_idx, n_rd_idx;
    t_ent_tag              r_tag, n_tag;
    logic                  r_hit, n_hit;
    logic                  r_status, n_status;
    logic                  r_out_valid, n_out_valid;
    logic [MARGIN_W-1:0]   r_x_margin;
    logic [MARGIN_W-1:0]   r_y_margin;

    // Payload held for the query in progress and for the result word.
    logic signed [W-1:0]     r_ax, r_ay, r_bx, r_by;
    logic signed [BND_W-1:0] r_dx, r_dy;
    logic                    r_out_hit;
    logic                    r_out_status;
    logic [COUNT_OUT_W-1:0]  r_out_count;

    logic                  w_accept;
    logic                  w_full;
    logic                  w_wr_en;
    logic                  w_last_idx;
    logic                  w_load_out;
    logic signed [BND_W-1:0] w_left, w_right, w_top, w_bottom;
    t_touch_res            w_res;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CNT_W'(MAX_OBSTACLES));
    assign w_wr_en       = w_accept && (s_axis_tuser == ACT_APPEND) && !w_full;
    assign w_last_idx    = ((CNT_W'(r_rd_idx) + CNT_W'(1)) == r_count);
    assign w_load_out    = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    // Register writes; an index outside the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_margin <= '0;
            r_y_margin <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_X_MARGIN: r_x_margin <= i_cfg_data;
                CFG_Y_MARGIN: r_y_margin <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer. Clear and append finish in the accept cycle; a query walks
    // the table one entry per cycle and then waits for the pipeline to drain.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_tag       = '0;
        n_hit       = r_hit;
        n_status    = r_status;
        n_out_valid = r_out_valid;

        if (m_axis_tvalid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        // Entry verdicts arrive only while a query is in progress.
        if (w_res.vld && w_res.touch) begin
            n_hit = 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_hit    = 1'b0;
                    n_status = 1'b0;
                    n_state  = ST_DONE;
                    case (s_axis_tuser)
                        ACT_CLEAR: begin
                            n_count = '0;
                        end
                        ACT_APPEND: begin
                            if (w_full) begin
                                n_status = 1'b1;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        ACT_QUERY: begin
                            n_rd_idx = '0;
                            if (r_count != '0) begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_tag.vld  = 1'b1;
                n_tag.last = w_last_idx;
                n_rd_idx   = r_rd_idx + IDX_W'(1);
                if (w_last_idx) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_res.vld && w_res.last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_tag       <= '0;
            r_hit       <= 1'b0;
            r_status    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_tag       <= n_tag;
            r_hit       <= n_hit;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    // The segment and its direction stay put for the whole table walk.
    always_ff @(posedge i_clk) begin
        if (w_accept && (s_axis_tuser == ACT_QUERY)) begin
            r_ax <= w_seg_start_x;
            r_ay <= w_seg_start_y;
            r_bx <= w_seg_end_x;
            r_by <= w_seg_end_y;
            r_dx <= BND_W'(w_seg_end_x) - BND_W'(w_seg_start_x);
            r_dy <= BND_W'(w_seg_end_y) - BND_W'(w_seg_start_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_hit    <= r_hit;
            r_out_status <= r_status;
            r_out_count  <= COUNT_OUT_W'(r_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_count, r_out_status, r_out_hit};

    src_obs_table #(
        .COORD_WIDTH   (COORD_WIDTH),
        .MAX_OBSTACLES (MAX_OBSTACLES)
    ) u_table (
        .i_clk        (i_clk),
        .i_wr_en      (w_wr_en),
        .i_wr_idx     (IDX_W'(r_count)),
        .i_center_x   (w_center_x),
        .i_center_y   (w_center_y),
        .i_box_length (w_box_length),
        .i_box_width  (w_box_width),
        .i_x_margin   (r_x_margin),
        .i_y_margin   (r_y_margin),
        .i_rd_idx     (r_rd_idx),
        .o_left       (w_left),
        .o_right      (w_right),
        .o_top        (w_top),
        .o_bottom     (w_bottom)
    );

    src_touch_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_touch (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (r_tag),
        .i_left   (w_left),
        .i_right  (w_right),
        .i_top    (w_top),
        .i_bottom (w_bottom),
        .i_ax     (r_ax),
        .i_ay     (r_ay),
        .i_bx     (r_bx),
        .i_by     (r_by),
        .i_dx     (r_dx),
        .i_dy     (r_dy),
        .o_res    (w_res)
    );

endmodule
`default_nettype wire

// ===== rtl/src_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// src_checker: port-level checks of the collision block
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module src_checker #(
    parameter int MAX_OBSTACLES = 64
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [src_pkg::OUT_DW-1:0]    m_axis_tdata
);
    import src_pkg::*;

    logic                   w_hit;
    logic                   w_status;
    logic [COUNT_OUT_W-1:0] w_count;

    assign w_hit    = m_axis_tdata[0];
    assign w_status = m_axis_tdata[1];
    assign w_count  = m_axis_tdata[2 +: COUNT_OUT_W];

    // One item at a time: an accepted word closes the input for the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted again right after an accept");

    // A dropped append never reports a hit.
    a_hit_status_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(w_hit && w_status))
        else $error("hit and status both set");

    // A dropped append only happens with a full table.
    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_status |-> w_count == COUNT_OUT_W'(MAX_OBSTACLES))
        else $error("append dropped while table not full");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

endmodule

bind segment_rectangle_collision src_checker #(
    .MAX_OBSTACLES (MAX_OBSTACLES)
) u_src_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== tb/sv/tb_segment_rectangle_collision.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segment_rectangle_collision: self-checking bench of the collision block
// A short table of directed words comes first. Random runs of clear, append
// and query words follow, with random stalls on both stream sides and margin
// rewrites between runs. The bench keeps its own obstacle table, predicts
// every result word from it, and compares each result field by field in order.
// ----------------------------------------------------------------------------
module tb_segment_rectangle_collision;
    import src_pkg::*;

    localparam int     COORD_W     = 24;
    localparam int     TABLE_DEPTH = 64;
    localparam int     IN_W        = ((6 * COORD_W + 2 * EXTENT_W + 7) / 8) * 8;
    localparam longint COORD_MAX   = (longint'(1) << (COORD_W - 1)) - 1;
    localparam longint COORD_MIN   = -(longint'(1) << (COORD_W - 1));
    localparam longint BOUND_MAX   = (longint'(1) << COORD_W) - 1;
    localparam longint BOUND_MIN   = -(longint'(1) << COORD_W);

    // The fourth action code has no name in the package; the block answers it but changes nothing.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int     RAND_WORDS  = 2000;
    localparam int     QUIET_TAIL  = 200;
    localparam int     LONG_HOLD   = 400;
    localparam int     TAIL_CYCLES = 80;
    localparam longint CYCLE_LIMIT = 1000000;

    // One input word, as the fields stand before packing.
    typedef struct {
        logic [ACTION_W-1:0]       action;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [EXTENT_W-1:0]       len;
        logic [EXTENT_W-1:0]       wid;
    } seg_word_t;

    // One result word.
    typedef struct packed {
        logic                   hit;
        logic                   status;
        logic [COUNT_OUT_W-1:0] count;
    } result_t;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

    // One row of the directed table: either a word sent reps times, or a
    // margin register write done while the block is idle.
    typedef struct {
        row_kind_e     kind;
        seg_word_t     w;
        logic          fixed_ok;
        result_t       fixed_res;
        int            reps;
        logic          reg_idx;
        logic [15:0]   reg_val;
    } plan_row_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // tdata from bit 0 up: seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    // center_x, center_y, box_length, box_width.
    logic [IN_W-1:0]        s_axis_tdata;
    // tuser: action.
    logic [ACTION_W-1:0]    s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // tdata from bit 0 up: hit, status, stored_count, zero fill.
    logic [OUT_DW-1:0]      m_axis_tdata;
    logic                   i_cfg_we;
    logic                   i_cfg_addr;
    logic [MARGIN_W-1:0]    i_cfg_data;

    segment_rectangle_collision #(
        .MAX_OBSTACLES (TABLE_DEPTH),
        .COORD_WIDTH   (COORD_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    // The bench copy of the obstacle table and of the margin registers.
    longint          box_lo_x [TABLE_DEPTH];
    longint          box_hi_x [TABLE_DEPTH];
    longint          box_lo_y [TABLE_DEPTH];
    longint          box_hi_y [TABLE_DEPTH];
    int              box_count = 0;
    logic [15:0]     margin_x  = '0;
    logic [15:0]     margin_y  = '0;

    // Results owed by the block, oldest first.
    result_t         pending[$];

    // The word on the input bus, with a typed-in result where the row has one.
    seg_word_t       bus_word;
    logic            bus_fixed_ok;
    result_t         bus_fixed;

    plan_row_t       plan[$];
    int              fail_count  = 0;
    longint          cycle_no    = 0;
    int              live_words  = 0;
    bit              tx_calm     = 1'b0;
    bit              quiet_phase = 1'b0;
    bit              hold_request = 1'b0;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic longint clamp_bound(input longint v);
        if (v > BOUND_MAX) return BOUND_MAX;
        if (v < BOUND_MIN) return BOUND_MIN;
        return v;
    endfunction

    // Sign of the cross product that says on which side of p-q the point r is.
    function automatic t_sgn orient_sign(input longint px, input longint py,
                                         input longint qx, input longint qy,
                                         input longint rx, input longint ry);
        longint v;
        v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
        if (v == 0) return SG_ZERO;
        return (v > 0) ? SG_POS : SG_NEG;
    endfunction

    // Segment a-b against side c-d, three-valued test with no collinear case.
    function automatic bit crosses_side(input longint ax, input longint ay,
                                        input longint bx, input longint by,
                                        input longint cx, input longint cy,
                                        input longint dx, input longint dy);
        t_sgn o1, o2, o3, o4;
        o1 = orient_sign(ax, ay, bx, by, cx, cy);
        o2 = orient_sign(ax, ay, bx, by, dx, dy);
        o3 = orient_sign(cx, cy, dx, dy, ax, ay);
        o4 = orient_sign(cx, cy, dx, dy, bx, by);
        return (o1 != o2) && (o3 != o4);
    endfunction

    function automatic bit point_in_box(input longint px, input longint py, input int i);
        return box_lo_x[i] <= px && px <= box_hi_x[i] &&
               box_lo_y[i] <= py && py <= box_hi_y[i];
    endfunction

    function automatic bit segment_touches(input longint ax, input longint ay,
                                           input longint bx, input longint by,
                                           input int i);
        longint l, r, t, b;
        l = box_lo_x[i];
        r = box_hi_x[i];
        t = box_hi_y[i];
        b = box_lo_y[i];
        return point_in_box(ax, ay, i) || point_in_box(bx, by, i) ||
               crosses_side(ax, ay, bx, by, l, t, r, t) ||
               crosses_side(ax, ay, bx, by, l, b, r, b) ||
               crosses_side(ax, ay, bx, by, l, t, l, b) ||
               crosses_side(ax, ay, bx, by, r, t, r, b);
    endfunction

    // Applies one accepted word to the bench table and returns its result.
    function automatic result_t step_obstacle_table(input seg_word_t w);
        result_t r;
        longint  hx, hy;
        r = '{hit: 1'b0, status: 1'b0, count: '0};
        case (w.action)
            ACT_CLEAR: begin
                box_count = 0;
            end
            ACT_APPEND: begin
                if (box_count >= TABLE_DEPTH) begin
                    r.status = 1'b1;
                end else begin
                    // The margins in force now are baked into the stored bounds.
                    hx = longint'(w.len >> 1) + longint'(margin_x);
                    hy = longint'(w.wid >> 1) + longint'(margin_y);
                    box_lo_x[box_count] = clamp_bound(longint'(w.cx) - hx);
                    box_hi_x[box_count] = clamp_bound(longint'(w.cx) + hx);
                    box_lo_y[box_count] = clamp_bound(longint'(w.cy) - hy);
                    box_hi_y[box_count] = clamp_bound(longint'(w.cy) + hy);
                    box_count++;
                end
            end
            ACT_QUERY: begin
                for (int i = 0; i < box_count && !r.hit; i++) begin
                    if (segment_touches(longint'(w.sx), longint'(w.sy),
                                        longint'(w.ex), longint'(w.ey), i)) begin
                        r.hit = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        r.count = COUNT_OUT_W'(box_count);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, cycle count and watchdog
    // ------------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
    end

    // A hung handshake or a lost result word ends the run here.
    initial begin : watchdog
        while (cycle_no < CYCLE_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Monitor: both handshakes are sampled at the rising edge. A result word
    // is checked before the input word of the same edge is predicted; a new
    // input word can never produce its result in the same cycle.
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        result_t got;
        result_t want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.hit    = m_axis_tdata[0];
                got.status = m_axis_tdata[1];
                got.count  = m_axis_tdata[COUNT_OUT_W+1:2];
                if (pending.size() == 0) begin
                    fail_count++;
                    $display({"%0t ns: result word with nothing pending, expected none, ",
                              "actual hit %0d status %0d count %0d"},
                             $time, got.hit, got.status, got.count);
                end else begin
                    want = pending.pop_front();
                    check_field("hit", 8'(want.hit), 8'(got.hit));
                    check_field("status", 8'(want.status), 8'(got.status));
                    check_field("stored_count", 8'(want.count), 8'(got.count));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                // The predictor always runs so that its table keeps step, even
                // where the row carries a typed-in result.
                want = step_obstacle_table(bus_word);
                pending.push_back(bus_fixed_ok ? bus_fixed : want);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready comes in random bursts and random stalls, none in the quiet
    // tail, and one long hold-off on request from the stimulus.
    // ------------------------------------------------------------------------

    initial begin : receiver
        int n;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                hold_request = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (!quiet_phase && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(1, 18);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                n = $urandom_range(1, 40);
                repeat (n - 1) @(negedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Puts one word on the bus at a falling edge and holds it until accepted.
    task automatic send_word(input seg_word_t w, input logic fixed_ok,
                             input result_t fixed_res);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w.wid, w.len, w.cy, w.cx, w.ey, w.ex, w.sy, w.sx};
        s_axis_tuser  <= w.action;
        bus_word      <= w;
        bus_fixed_ok  <= fixed_ok;
        bus_fixed     <= fixed_res;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic idle_sender(input int n);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Sends one word, sometimes after a random gap.
    task automatic offer(input seg_word_t w, input logic fixed_ok, input result_t fixed_res);
        if (!tx_calm && $urandom_range(0, 4) == 0) idle_sender($urandom_range(1, 18));
        send_word(w, fixed_ok, fixed_res);
        if (w.action != ACT_UNUSED) live_words++;
    endtask

    // Stops sending and waits until every owed result word has come back.
    task automatic drain_results();
        idle_sender(1);
        while (pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_margin(input logic idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_X_MARGIN) margin_x = val;
        else margin_y = val;
    endtask

    // ------------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------------

    function automatic result_t mk_res(input logic hit, input logic status, input int count);
        result_t r;
        r.hit    = hit;
        r.status = status;
        r.count  = COUNT_OUT_W'(count);
        return r;
    endfunction

    function automatic seg_word_t mk_word(input logic [ACTION_W-1:0] act,
                                          input longint sx, input longint sy,
                                          input longint ex, input longint ey,
                                          input longint cx, input longint cy,
                                          input int len, input int wid);
        seg_word_t w;
        w.action = act;
        w.sx  = sx[COORD_W-1:0];
        w.sy  = sy[COORD_W-1:0];
        w.ex  = ex[COORD_W-1:0];
        w.ey  = ey[COORD_W-1:0];
        w.cx  = cx[COORD_W-1:0];
        w.cy  = cy[COORD_W-1:0];
        w.len = EXTENT_W'(len);
        w.wid = EXTENT_W'(wid);
        return w;
    endfunction

    // Every field random over its full width, so that unused fields toggle too.
    function automatic seg_word_t rand_word();
        seg_word_t w;
        w.action = ACTION_W'($urandom_range(0, 3));
        w.sx  = COORD_W'($urandom);
        w.sy  = COORD_W'($urandom);
        w.ex  = COORD_W'($urandom);
        w.ey  = COORD_W'($urandom);
        w.cx  = COORD_W'($urandom);
        w.cy  = COORD_W'($urandom);
        w.len = EXTENT_W'($urandom);
        w.wid = EXTENT_W'($urandom);
        return w;
    endfunction

    // A coordinate within span of the anchor, clipped to the signed range.
    function automatic logic signed [COORD_W-1:0] near(input longint anchor,
                                                       input int unsigned span);
        longint v;
        v = anchor + longint'($urandom_range(0, 2 * span)) - longint'(span);
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [EXTENT_W-1:0] pick_extent(input int unsigned span);
        int unsigned v;
        if ($urandom_range(0, 9) == 0) return EXTENT_W'($urandom);
        v = $urandom_range(0, 2 * span);
        if (v > 65535) v = 65535;
        return EXTENT_W'(v);
    endfunction

    function automatic logic [15:0] pick_margin();
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 64));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_word_row(input seg_word_t w, input logic fixed_ok,
                                input result_t fixed_res, input int reps);
        plan_row_t r;
        r.kind      = ROW_WORD;
        r.w         = w;
        r.fixed_ok  = fixed_ok;
        r.fixed_res = fixed_res;
        r.reps      = reps;
        r.reg_idx   = CFG_X_MARGIN;
        r.reg_val   = '0;
        plan.push_back(r);
    endtask

    task automatic add_reg_row(input logic idx, input logic [15:0] val);
        plan_row_t r;
        r.kind      = ROW_REG;
        r.w         = mk_word(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        r.fixed_ok  = 1'b0;
        r.fixed_res = mk_res(0, 0, 0);
        r.reps      = 0;
        r.reg_idx   = idx;
        r.reg_val   = val;
        plan.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    initial begin : stimulus
        seg_word_t   w;
        result_t     none;
        int          seq_no;
        int unsigned span;
        longint      anchor_x;
        longint      anchor_y;
        int          n_app;
        int          n_qry;
        bit          overfill;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_CLEAR;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_X_MARGIN;
        i_cfg_data    = '0;
        bus_word      = mk_word(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        bus_fixed_ok  = 1'b0;
        bus_fixed     = mk_res(0, 0, 0);
        none          = mk_res(0, 0, 0);

        // Directed table. Typed-in results only after reset, on clears, on the first
        // append, on extremes and on the full-table drop; the rest is predicted.
        // Query on the empty table just after reset, with extreme endpoints.
        add_word_row(mk_word(ACT_QUERY, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                             0, 0, 0, 0), 1'b1, mk_res(0, 0, 0), 1);
        add_word_row(mk_word(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0), 1);
        // The unused action with every field at all ones does nothing.
        add_word_row(mk_word(ACT_UNUSED, -1, -1, -1, -1, -1, -1, 65535, 65535),
                     1'b1, mk_res(0, 0, 0), 1);
        // Box spanning x -256..256 and y -128..128 with zero margins.
        add_word_row(mk_word(ACT_APPEND, 0, 0, 0, 0, 0, 0, 512, 256),
                     1'b1, mk_res(0, 0, 1), 1);
        // Zero-length segment inside, endpoint on a corner, a crossing with both
        // ends outside, a clean miss, collinear with the top side but beyond
        // it, collinear along the whole top side, and a near miss at a corner.
        add_word_row(mk_word(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none, 1);
        add_word_row(mk_word(ACT_QUERY, 256, 128, 1000, 1000, 0, 0, 0, 0), 1'b0, none, 1);
        add_word_row(mk_word(ACT_QUERY, -1000, 0, 1000, 0, 0, 0, 0, 0), 1'b0, none, 1);
        add_word_row(mk_word(ACT_QUERY, -1000, 1000, 1000, 1000, 0, 0, 0, 0), 1'b0, none, 1);
        add_word_row(mk_word(ACT_QUERY, 300, 128, 600, 128, 0, 0, 0, 0), 1'b0, none, 1);
        add_word_row(mk_word(ACT_QUERY, -1000, 128, 1000, 128, 0, 0, 0, 0), 1'b0, none, 1);
        add_word_row(mk_word(ACT_QUERY, 257, 129, 1000, 1000, 0, 0, 0, 0), 1'b0, none, 1);
        // Largest margins and extents at the corner of the coordinate range.
        add_reg_row(CFG_X_MARGIN, 16'hFFFF);
        add_reg_row(CFG_Y_MARGIN, 16'hFFFF);
        add_word_row(mk_word(ACT_APPEND, 0, 0, 0, 0, COORD_MAX, COORD_MIN, 65535, 65535),
                     1'b1, mk_res(0, 0, 2), 1);
        // Margins written later must not move the stored bounds.
        add_reg_row(CFG_X_MARGIN, 16'h0000);
        add_reg_row(CFG_Y_MARGIN, 16'h0000);
        add_word_row(mk_word(ACT_QUERY, COORD_MAX - 90000, COORD_MIN + 90000,
                             COORD_MAX - 90000, COORD_MIN + 90000, 0, 0, 0, 0),
                     1'b0, none, 1);
        add_word_row(mk_word(ACT_QUERY, COORD_MIN, COORD_MIN, 0, COORD_MIN, 0, 0, 0, 0),
                     1'b0, none, 1);
        // A one-by-zero extent halves to a single point.
        add_word_row(mk_word(ACT_APPEND, 0, 0, 0, 0, 100, -50, 1, 0), 1'b0, none, 1);
        add_word_row(mk_word(ACT_QUERY, 90, -60, 110, -40, 0, 0, 0, 0), 1'b0, none, 1);
        add_word_row(mk_word(ACT_QUERY, 100, -50, 200, 0, 0, 0, 0, 0), 1'b0, none, 1);
        // Fill the table, then one append too many is dropped and flagged.
        add_word_row(mk_word(ACT_APPEND, 0, 0, 0, 0, 5000, 5000, 300, 300), 1'b0, none, 61);
        add_word_row(mk_word(ACT_APPEND, 0, 0, 0, 0, -5000, -5000, 300, 300),
                     1'b1, mk_res(0, 1, 64), 1);
        add_word_row(mk_word(ACT_QUERY, -5000, -5000, -4000, -4000, 0, 0, 0, 0),
                     1'b0, none, 1);
        add_word_row(mk_word(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0), 1);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_REG) begin
                drain_results();
                write_margin(plan[r].reg_idx, plan[r].reg_val);
            end else begin
                repeat (plan[r].reps) offer(plan[r].w, plan[r].fixed_ok, plan[r].fixed_res);
            end
        end

        // Random runs: an optional clear, appends near an anchor (up to six, or an
        // overfill of 60 to 70) and queries around them, with some noise words mixed in.
        live_words = 0;
        seq_no = 0;
        while (live_words < RAND_WORDS) begin
            seq_no++;
            quiet_phase = (live_words >= RAND_WORDS - QUIET_TAIL);
            tx_calm = quiet_phase || ($urandom_range(0, 2) == 0);

            if (seq_no % 7 == 3) begin
                drain_results();
                write_margin(CFG_X_MARGIN, pick_margin());
                write_margin(CFG_Y_MARGIN, pick_margin());
            end

            // Once, the receiver holds off for a long stretch while this run
            // is offered back to back, so the block fills and stalls its input.
            if (seq_no == 12) begin
                hold_request = 1'b1;
                tx_calm = 1'b1;
            end

            case ($urandom_range(0, 3))
                0:       span = 8;
                1:       span = 256;
                2:       span = 4096;
                default: span = 65535;
            endcase
            if ($urandom_range(0, 7) == 0) begin
                anchor_x = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
                anchor_y = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            end else begin
                anchor_x = longint'($urandom_range(0, 1 << 23)) - (longint'(1) << 22);
                anchor_y = longint'($urandom_range(0, 1 << 23)) - (longint'(1) << 22);
            end

            overfill = ($urandom_range(0, 19) == 0);
            n_app = overfill ? $urandom_range(60, 70) : $urandom_range(0, 6);
            n_qry = $urandom_range(1, 8);

            if (overfill || box_count > 40 || $urandom_range(0, 3) != 0) begin
                w = rand_word();
                w.action = ACT_CLEAR;
                offer(w, 1'b0, none);
            end

            while (n_app + n_qry > 0) begin
                w = rand_word();
                if ($urandom_range(0, 9) == 0) begin
                    // Noise: any action with full-range content, which may
                    // clear the table in the middle of the run.
                end else if (n_app > 0 && (n_qry == 0 || $urandom_range(0, 2) != 0)) begin
                    n_app--;
                    w.action = ACT_APPEND;
                    w.cx  = near(anchor_x, span);
                    w.cy  = near(anchor_y, span);
                    w.len = pick_extent(span);
                    w.wid = pick_extent(span);
                end else begin
                    n_qry--;
                    w.action = ACT_QUERY;
                    w.sx = near(anchor_x, 2 * span);
                    w.sy = near(anchor_y, 2 * span);
                    w.ex = near(anchor_x, 2 * span);
                    w.ey = near(anchor_y, 2 * span);
                    // Axis-parallel and zero-length segments bring out the
                    // collinear cases of the side test.
                    if ($urandom_range(0, 7) == 0) w.ex = w.sx;
                    if ($urandom_range(0, 7) == 0) w.ey = w.sy;
                end
                offer(w, 1'b0, none);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
